// ===== src/clnu_pkg.sv =====
`default_nettype none

package clnu_pkg;

	// byte codes used by the scanner
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_Z     = 8'h5a;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// record kinds
	localparam logic [1:0] KIND_CHAR     = 2'd0;
	localparam logic [1:0] KIND_END      = 2'd1;
	localparam logic [1:0] KIND_OVERFLOW = 2'd2;

	localparam int MAX_RESULTS = 4;
	localparam int REC_CNT_W   = 3;
	localparam int LEN_W       = 17;   // limit plus one fits

	localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_SLASH,
		MODE_BLOCK,
		MODE_BSTAR,
		MODE_LINE,
		MODE_QUOTE,
		MODE_CR_END,
		MODE_CR_MID
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [7:0]  out_char;
		logic [15:0] line_length;
		logic [15:0] lines_joined;
		logic        last_result;
	} out_word_t;

	typedef struct packed {
		scan_mode_t       scan_mode;
		logic             space_pending;
		logic             suppress_space;
		logic [7:0]       last_visible;
		logic [LEN_W-1:0] length_count;
		logic [15:0]      joined_count;
	} scan_state_t;

	typedef struct packed {
		out_word_t [MAX_RESULTS-1:0] recs;
		logic [REC_CNT_W-1:0]        count;
	} step_result_t;

endpackage

`default_nettype wire

// ===== src/clnu_step.sv =====
`default_nettype none

module clnu_step (
	input  clnu_pkg::scan_state_t  cur,
	input  clnu_pkg::in_word_t     word,
	input  logic [15:0]            max_len,
	output clnu_pkg::scan_state_t  nxt,
	output clnu_pkg::step_result_t res
);
	import clnu_pkg::*;

	typedef struct packed {
		scan_state_t                 st;
		out_word_t [MAX_RESULTS-1:0] recs;
		logic [REC_CNT_W-1:0]        cnt;
		logic                        closed;
		logic                        hit;
	} ctx_t;

	function automatic ctx_t f_push(ctx_t c, logic [1:0] kind, logic [7:0] ch,
			logic [LEN_W-1:0] len, logic [15:0] jn);
		ctx_t r;
		out_word_t w;
		r = c;
		w.record_kind  = kind;
		w.out_char     = ch;
		w.line_length  = (len > LEN_W'(16'hffff)) ? 16'hffff : len[15:0];
		w.lines_joined = jn;
		w.last_result  = 1'b0;
		// anything past four records in one step is dropped
		if (c.cnt < REC_CNT_W'(MAX_RESULTS)) begin
			r.recs[c.cnt[1:0]] = w;
			r.cnt = c.cnt + REC_CNT_W'(1);
		end
		return r;
	endfunction

	function automatic ctx_t f_new_line(ctx_t c);
		ctx_t r;
		r = c;
		r.st.scan_mode      = MODE_NORMAL;
		r.st.space_pending  = 1'b0;
		r.st.suppress_space = 1'b1;
		r.st.last_visible   = 8'd0;
		r.st.length_count   = '0;
		r.st.joined_count   = 16'd0;
		return r;
	endfunction

	function automatic ctx_t f_add_joined(ctx_t c);
		ctx_t r;
		r = c;
		if (c.st.joined_count != 16'hffff)
			r.st.joined_count = c.st.joined_count + 16'd1;
		return r;
	endfunction

	function automatic ctx_t f_put_char(ctx_t c, logic [7:0] ch);
		ctx_t r;
		r = c;
		if (r.st.space_pending) begin
			r = f_push(r, KIND_CHAR, CH_SPACE, '0, 16'd0);
			r.st.space_pending = 1'b0;
		end
		r = f_push(r, KIND_CHAR, ch, '0, 16'd0);
		r.st.length_count   = r.st.length_count + LEN_W'(1);
		r.st.suppress_space = 1'b0;
		return r;
	endfunction

	function automatic ctx_t f_check_ovf(ctx_t c, logic [LEN_W-1:0] lim);
		ctx_t r;
		r = c;
		r.hit = 1'b0;
		if (c.st.length_count >= lim) begin
			r = f_push(r, KIND_OVERFLOW, 8'd0, c.st.length_count, c.st.joined_count);
			r = f_new_line(r);
			r.closed = 1'b1;
			r.hit = 1'b1;
		end
		return r;
	endfunction

	function automatic ctx_t f_end_line(ctx_t c);
		ctx_t r;
		logic [LEN_W-1:0] len;
		r = c;
		// a pending space is not part of the line
		len = c.st.length_count - LEN_W'(c.st.space_pending);
		r = f_push(r, KIND_END, 8'd0, len, c.st.joined_count);
		r = f_new_line(r);
		r.closed = 1'b1;
		return r;
	endfunction

	function automatic ctx_t f_normal_byte(ctx_t c, logic [7:0] ch, logic [LEN_W-1:0] lim);
		ctx_t r;
		logic go_space;
		r = c;
		go_space = 1'b1;
		if (ch > CH_SPACE) begin
			if (ch == CH_SLASH) begin
				// held until the next byte shows whether a comment opens
				r.st.scan_mode    = MODE_SLASH;
				r.st.last_visible = ch;
			end else begin
				r = f_put_char(r, ch);
				r.st.last_visible = ch;
				if (ch == CH_QUOTE)
					r.st.scan_mode = MODE_QUOTE;
				r = f_check_ovf(r, lim);
			end
		end else begin
			if (ch == CH_CR) begin
				if (r.st.last_visible != CH_BSL) begin
					r = f_end_line(r);
					r.st.scan_mode = MODE_CR_END;
					go_space = 1'b0;
				end else begin
					r = f_add_joined(r);
					r.st.scan_mode = MODE_CR_MID;
				end
			end
			if (go_space && !r.st.suppress_space) begin
				r.st.space_pending  = 1'b1;
				r.st.suppress_space = 1'b1;
				r.st.length_count   = r.st.length_count + LEN_W'(1);
				r = f_check_ovf(r, lim);
				if (r.hit && ch == CH_CR)
					r.st.scan_mode = MODE_CR_END;
			end
		end
		return r;
	endfunction

	ctx_t             c;
	logic             swallowed;
	logic [7:0]       ch;
	logic [LEN_W-1:0] lim;

	always_comb begin
		ch  = word.in_byte;
		lim = (max_len == 16'd0) ? LEN_W'(1) : LEN_W'(max_len);
		c.st     = cur;
		c.recs   = '0;
		c.cnt    = '0;
		c.closed = 1'b0;
		c.hit    = 1'b0;
		swallowed = 1'b0;

		case (cur.scan_mode)
			MODE_SLASH: begin
				if (ch == CH_STAR) begin
					c.st.scan_mode = MODE_BLOCK;
				end else if (ch == CH_SLASH) begin
					c.st.scan_mode = MODE_LINE;
				end else begin
					c.st.scan_mode = MODE_NORMAL;
					c = f_put_char(c, CH_SLASH);
					c = f_check_ovf(c, lim);
					c = f_normal_byte(c, ch, lim);
				end
			end
			MODE_BLOCK, MODE_BSTAR: begin
				if (cur.scan_mode == MODE_BSTAR && ch == CH_SLASH) begin
					c.st.scan_mode = MODE_NORMAL;
				end else if (ch == CH_STAR) begin
					c.st.scan_mode = MODE_BSTAR;
				end else begin
					c.st.scan_mode = MODE_BLOCK;
					if (ch == CH_CR)
						c = f_add_joined(c);
				end
				if (ch > CH_SPACE)
					c.st.last_visible = ch;
			end
			MODE_LINE: begin
				if (ch == CH_CR) begin
					if (cur.length_count != '0) begin
						c = f_end_line(c);
						c.st.scan_mode = MODE_CR_END;
					end else begin
						c = f_add_joined(c);
						c.st.scan_mode = MODE_CR_MID;
					end
				end else if (ch > CH_SPACE) begin
					c.st.last_visible = ch;
				end
			end
			MODE_QUOTE: begin
				if (ch == CH_QUOTE && cur.last_visible != CH_BSL) begin
					c = f_put_char(c, CH_Z);
					c = f_put_char(c, CH_QUOTE);
					c.st.scan_mode    = MODE_NORMAL;
					c.st.last_visible = ch;
					c = f_check_ovf(c, lim);
				end else if (ch > CH_SPACE) begin
					c.st.last_visible = ch;
				end
			end
			MODE_CR_END, MODE_CR_MID: begin
				c.st.scan_mode = MODE_NORMAL;
				if (ch == CH_LF)
					swallowed = (cur.scan_mode == MODE_CR_END);
				else
					c = f_normal_byte(c, ch, lim);
			end
			default: begin
				c = f_normal_byte(c, ch, lim);
			end
		endcase

		// end of buffer closes whatever is open
		if (word.last_byte) begin
			if (c.st.scan_mode == MODE_SLASH) begin
				c.st.scan_mode = MODE_NORMAL;
				c = f_put_char(c, CH_SLASH);
				c = f_check_ovf(c, lim);
			end
			if (!c.closed && !swallowed)
				c = f_end_line(c);
			c = f_new_line(c);
		end

		if (c.cnt != '0)
			c.recs[c.cnt[1:0] - 2'd1].last_result = 1'b1;

		nxt       = c.st;
		res.recs  = c.recs;
		res.count = c.cnt;
	end

endmodule

`default_nettype wire

// ===== src/clnu_queue.sv =====
`default_nettype none

module clnu_queue #(
	parameter int DEPTH_LOG2 = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_en,
	input  clnu_pkg::step_result_t push_res,
	output logic                   room4,
	output logic                   rec_valid,
	input  logic                   rec_stall,
	output clnu_pkg::out_word_t    rec_word
);
	import clnu_pkg::*;

	localparam int DEPTH = 1 << DEPTH_LOG2;
	localparam int PTR_W = DEPTH_LOG2;
	localparam int CNT_W = DEPTH_LOG2 + 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	out_word_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] push_n;
	logic             pop;

	assign push_n    = push_en ? CNT_W'(push_res.count) : '0;
	assign rec_valid = (count_q != '0);
	assign rec_word  = mem_q[rd_ptr_q];
	assign pop       = rec_valid && !rec_stall;
	assign room4     = ((DEPTH_C - count_q) >= CNT_W'(MAX_RESULTS));

	// up to four entries land together in a single write
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (push_en && (REC_CNT_W'(k) < push_res.count))
				mem_q[wr_ptr_q + PTR_W'(k)] <= push_res.recs[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + push_n - CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count beyond depth");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> ((CNT_W + 1)'(count_q) + (CNT_W + 1)'(push_res.count)
			<= (CNT_W + 1)'(DEPTH)))
		else $error("queue push without room");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!push_en && pop) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("queue count wrong after pop");
`endif

endmodule

`default_nettype wire

// ===== src/c_source_line_normalizer_unit.sv =====
`default_nettype none

// channel  | handshake              | word                | direction
// ---------+------------------------+---------------------+----------
// byte     | byte_valid/byte_stall  | in_byte, last_byte  | into block
// rec      | rec_valid/rec_stall    | one result record   | out of block
// cfg      | cfg_wr_en              | max_line_length     | into block
//
// one byte is taken per cycle while the result queue has four free slots;
// records leave at one per cycle while rec_stall is low, so sustained input
// rate is one byte per record emitted
// an accepted byte is held in the byte register; its records are written to
// the result queue when it is processed and show on the output in order
// reset returns the scanner to the start of a line and the limit to 1024
// a stalled record output backs up the queue, then holds the byte register

module c_source_line_normalizer_unit #(
	parameter int QUEUE_DEPTH_LOG2 = 3   // 2 to 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  clnu_pkg::in_word_t  byte_word,
	output logic                rec_valid,
	input  logic                rec_stall,
	output clnu_pkg::out_word_t rec_word,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data
);
	import clnu_pkg::*;

	// input register holding the byte under work
	in_word_t     word_s1;
	logic         valid_s1;

	// scanner state and limit register
	scan_state_t  state_q;
	logic [15:0]  max_len_q;

	scan_state_t  state_nxt;
	step_result_t step_res;
	logic         room4;
	logic         advance;
	logic         byte_accept;

	// the held byte is processed once the queue can take a full burst
	assign advance     = valid_s1 && room4;
	assign byte_stall  = valid_s1 && !room4;
	assign byte_accept = byte_valid && !byte_stall;

	always_ff @(posedge clk) begin
		if (byte_accept)
			word_s1 <= byte_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= byte_accept || (valid_s1 && !advance);
		end
	end

	// limit register; the user must write it only between buffers, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// scanner state, line start after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.scan_mode      <= MODE_NORMAL;
			state_q.space_pending  <= 1'b0;
			state_q.suppress_space <= 1'b1;
			state_q.last_visible   <= 8'd0;
			state_q.length_count   <= '0;
			state_q.joined_count   <= 16'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// one byte in, up to four records out
	clnu_step u_step (
		.cur     (state_q),
		.word    (word_s1),
		.max_len (max_len_q),
		.nxt     (state_nxt),
		.res     (step_res)
	);

	// result queue parts the scanner from the output handshake
	clnu_queue #(
		.DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (advance),
		.push_res  (step_res),
		.room4     (room4),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_word  (rec_word)
	);

`ifndef SYNTHESIS
	a_hold_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room4) |=> (valid_s1 && $stable(word_s1)))
		else $error("held byte lost while queue full");

	a_recs_show: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.count != '0) |=> rec_valid)
		else $error("records written but queue empty");

	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> $onehot0({step_res.recs[3].last_result, step_res.recs[2].last_result,
			step_res.recs[1].last_result, step_res.recs[0].last_result}))
		else $error("more than one last record in a step");
`endif

endmodule

`default_nettype wire
